// ----- src/sorted_priority_queue_core_macros.svh -----
// Assertion macros shared by the priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and off during rst.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off during rst.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// Package: types, constants and codes of the sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [DATA_W-1:0]   item_value;
    logic [DATA_W-1:0]   item_rank;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   out_value;
    logic [DATA_W-1:0]   out_rank;
    status_t             status;
    logic [3:0]          occupancy;
    logic                is_empty;
    logic                is_full;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   rank;
  } slot_t;

  typedef struct packed {
    logic                ins;
    logic                rem;
    slot_t               item;
  } cell_ctl_t;

endpackage

// ----- src/sorted_priority_queue_core.sv -----
// Sorted priority queue: a row of compare-and-shift slots behind an output register.
//
// Input channel in_valid/in_stall/in_data carries one operation per transaction:
// insert a data/priority pair, or remove the highest-priority pair. Pairs are kept
// in descending priority; equal priorities leave in arrival order.
// Output channel out_valid/out_stall/out_data returns one result per operation:
// removed pair (-1/-1 when empty, 0/0 on insert), status, occupancy, empty and full.
// The result of an accepted transaction is registered into out_data and shown in the next cycle.
// Throughput is one operation per cycle while no held result is stalled: every slot
// compares its rank with the incoming one and shifts toward its neighbor in the same
// cycle that the operation is accepted; the occupancy counter updates alongside.
// A full queue rejects an insert unchanged; an empty queue answers a remove unchanged.
// While the receiver stalls a held result, in_stall is high and no operation enters.
// Reset clears the occupancy counter and the output valid; slot contents are
// left as they are and never read before being written.
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  cell_ctl_t        ctl;
  out_t             result;
  slot_t            slots [QUEUE_DEPTH];
  logic             gts   [QUEUE_DEPTH];
  logic             valids[QUEUE_DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    ctl.ins        = accept && (in_data.func == FUNC_INSERT) && !is_full;
    ctl.rem        = accept && (in_data.func == FUNC_REMOVE) && !is_empty;
    ctl.item.value = in_data.item_value;
    ctl.item.rank  = in_data.item_rank;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left;
    slot_t right;
    logic  left_gt;
    logic  left_valid;

    assign valids[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left       = ctl.item;
      assign left_gt    = 1'b0;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left       = slots[i-1];
      assign left_gt    = gts[i-1];
      assign left_valid = valids[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right = slots[i];
    end else begin : g_mid
      assign right = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (valids[i]),
      .left_valid (left_valid),
      .left_gt    (left_gt),
      .left       (left),
      .right      (right),
      .slot       (slots[i]),
      .gt         (gts[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    result.out_value = '0;
    result.out_rank  = '0;
    result.status    = ST_DONE;
    if (in_data.func == FUNC_INSERT) begin
      if (is_full) begin
        result.status = ST_FULL;
      end
    end else if (is_empty) begin
      result.status    = ST_EMPTY;
      result.out_value = '1;
      result.out_rank  = '1;
    end else begin
      result.out_value = slots[0].value;
      result.out_rank  = slots[0].rank;
    end
    result.occupancy = 4'(count_next);
    result.is_empty  = (count_next == '0);
    result.is_full   = (count_next == CNT_W'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ----- src/spq_cell.sv -----
// One queue slot: compares against the incoming pair and shifts with its neighbors.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  logic      left_valid,
  input  logic      left_gt,
  input  slot_t     left,
  input  slot_t     right,
  output slot_t     slot,
  output logic      gt
);

  assign gt = valid && ($signed(ctl.item.rank) > $signed(slot.rank));

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_gt) begin
        slot <= left;
      end else if (gt || (!valid && left_valid)) begin
        slot <= ctl.item;
      end
    end else if (ctl.rem) begin
      slot <= right;
    end
  end

endmodule

// ----- src/spq_checker.sv -----
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_core_macros.svh"

module spq_checker import spq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `SPQ_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid, "accepted transaction gave no result")
  `SPQ_ASSERT_NOW(a_empty_count, out_valid && out_data.is_empty, out_data.occupancy == 4'd0, "empty flag with nonzero occupancy")
  `SPQ_ASSERT_NOW(a_reject_full, out_valid && (out_data.status == ST_FULL), out_data.is_full && (out_data.out_value == '0), "rejected insert without full queue")
  `SPQ_ASSERT_NOW(a_empty_remove, out_valid && (out_data.status == ST_EMPTY), out_data.is_empty && (out_data.out_rank == '1), "empty remove result malformed")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

// ----- dv/sorted_priority_queue_core_tb.sv -----
// Testbench for the sorted priority queue: random and directed operations vs a local model.
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 50;
  localparam int RANDOM_OPS = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  sorted_priority_queue_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  in_t pending_ops[$];
  out_t awaited_replies[$];
  slot_t held_slots[QUEUE_DEPTH];
  int held_count = 0;

  int ops_sent = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int inserts_done = 0;
  int inserts_rejected = 0;
  int removes_done = 0;
  int removes_on_empty = 0;
  int peak_occupancy = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_t make_op(func_t f, logic [DATA_W-1:0] v, logic [DATA_W-1:0] r);
    in_t op;
    op.func = f;
    op.item_value = v;
    op.item_rank = r;
    return op;
  endfunction

  // Apply one operation to the model queue and return the result it should give.
  function automatic out_t apply_queue_op(in_t op);
    out_t r;
    int pos;
    r = '0;
    r.status = ST_DONE;
    if (op.func == FUNC_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && $signed(op.item_rank) > $signed(held_slots[pos-1].rank)) begin
          held_slots[pos] = held_slots[pos-1];
          pos--;
        end
        held_slots[pos].value = op.item_value;
        held_slots[pos].rank = op.item_rank;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
        r.out_value = '1;
        r.out_rank = '1;
      end else begin
        r.out_value = held_slots[0].value;
        r.out_rank = held_slots[0].rank;
        for (int i = 0; i + 1 < held_count; i++) begin
          held_slots[i] = held_slots[i+1];
        end
        held_count--;
      end
    end
    r.occupancy = 4'(held_count);
    r.is_empty = (held_count == 0);
    r.is_full = (held_count == QUEUE_DEPTH);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] draw_rank();
    case ($urandom_range(0, 2))
      0: return 32'($urandom_range(0, 7)) - 32'd4;
      1: return $urandom();
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Driver: present the next operation once the previous one is taken and the gap ran out.
  always @(posedge clk) begin
    logic taken;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        awaited_replies.push_back(apply_queue_op(in_data));
        ops_sent++;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap_left = send_burst ? 0 : $urandom_range(0, 4);
      end
      if (in_valid && !taken) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_data <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result and draw the stall before the next one.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result %p at %0t", out_data, $realtime);
        end else begin
          want = awaited_replies.pop_front();
          if (out_data.out_value !== want.out_value || out_data.out_rank !== want.out_rank ||
              out_data.status !== want.status || out_data.occupancy !== want.occupancy ||
              out_data.is_empty !== want.is_empty || out_data.is_full !== want.is_full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d at %0t\n  expected %p\n  actual   %p",
                       replies_seen, $realtime, want, out_data);
          end
          if (want.status == ST_FULL) inserts_rejected++;
          if (want.status == ST_EMPTY) removes_on_empty++;
          if (int'(want.occupancy) > peak_occupancy) peak_occupancy = int'(want.occupancy);
        end
        if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
        if (replies_seen % 200 == 60) stall_left = HOLD_OFF_CYCLES;
        else stall_left = take_burst ? 0 : $urandom_range(0, 4);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int made;
    int bias;
    int run_len;
    int total_ops;
    in_t op;

    // empty queue, then fill with extreme and equal ranks, overflow, drain, underflow
    pending_ops.push_back(make_op(FUNC_REMOVE, 32'hffff_ffff, 32'hffff_ffff));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h7fff_ffff, 32'h0000_0000));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h0000_0000, 32'h8000_0000));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'hffff_ffff, 32'h0000_0000));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h0000_0001, 32'hffff_ffff));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h0000_0005, 32'h0000_0000));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'haaaa_aaaa, 32'h5555_5555));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'h5555_5555, 32'haaaa_aaaa));
    pending_ops.push_back(make_op(FUNC_INSERT, 32'hffff_ffff, 32'h7fff_ffff));
    repeat (QUEUE_DEPTH) pending_ops.push_back(make_op(FUNC_REMOVE, $urandom(), $urandom()));
    pending_ops.push_back(make_op(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000));

    made = 0;
    while (made < RANDOM_OPS) begin
      case ($urandom_range(0, 2))
        0: bias = 15;
        1: bias = 50;
        default: bias = 85;
      endcase
      run_len = $urandom_range(10, 40);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < bias)
          op = make_op(FUNC_INSERT, $urandom(), draw_rank());
        else
          op = make_op(FUNC_REMOVE, $urandom(), $urandom());
        if (op.func == FUNC_INSERT) inserts_done++;
        else removes_done++;
        pending_ops.push_back(op);
        made++;
      end
    end
    inserts_done += QUEUE_DEPTH + 1;
    removes_done += QUEUE_DEPTH + 2;
    total_ops = pending_ops.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (replies_seen < total_ops)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d operations: %0d inserts (%0d rejected full), %0d removes (%0d on empty)",
             ops_sent, inserts_done, inserts_rejected, removes_done, removes_on_empty);
    $display("Peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
             peak_occupancy, QUEUE_DEPTH, replies_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
